// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the ranging controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset
`define URC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define URC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/urc_pkg.sv -----
// ----------------------------------------------------------------------------
// urc_pkg
// Types, widths and constants for the ultrasonic ranging controller.
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int SINCE_W    = 24;
  localparam int CNT_W      = 16;
  localparam int CM_W       = 15;
  localparam int INCH_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [SINCE_W-1:0] INTERVAL_RST = SINCE_W'(2000000);
  localparam logic [CNT_W-1:0]   TRIG_W_RST   = CNT_W'(2000);
  localparam logic [CNT_W-1:0]   TIMEOUT_RST  = CNT_W'(30000);

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_W   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  // width*16/58 == floor(width*578525 / 2^21), exact for 16-bit widths
  localparam int                 CM_MUL_W   = 20;
  localparam logic [CM_MUL_W-1:0] CM_MUL    = CM_MUL_W'(578525);
  localparam int                 CM_SHIFT   = 21;
  // width*16/148 == floor(width*453439 / 2^22), exact for 16-bit widths
  localparam int                   INCH_MUL_W = 19;
  localparam logic [INCH_MUL_W-1:0] INCH_MUL  = INCH_MUL_W'(453439);
  localparam int                   INCH_SHIFT = 22;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

endpackage

// ----- rtl/core/ultrasonic_ranging_controller_core.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_ranging_controller_core
// Results are registered on acceptance. Throughput: one tick request per cycle
// unless a held result awaits out_ready, set by the single state/result
// register stage; the output register lets a new tick enter while the last
// result is taken. Reset (rst_n low, synchronous): sequencer idle, counters,
// echo tracking and held results cleared, registers back to their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_ranging_controller_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [urc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_echo_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_trigger_level,
  output logic                           out_measurement_done,
  output logic                           out_timed_out,
  output logic [urc_pkg::CM_W-1:0]       out_distance_cm_q4,
  output logic [urc_pkg::INCH_W-1:0]     out_distance_inch_q4
);
  import urc_pkg::*;

  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  // configuration
  logic [SINCE_W-1:0] interval_r;
  logic [CNT_W-1:0]   trig_w_r;
  logic [CNT_W-1:0]   timeout_r;

  // sequencer and echo tracking state
  phase_t             phase_r, phase_nxt;
  logic [SINCE_W-1:0] since_r, since_nxt;
  logic [CNT_W-1:0]   pcount_r, pcount_nxt;
  logic               echo_prev_r;
  logic [CNT_W-1:0]   echo_w_r, echo_w_nxt;
  logic               echo_seen_r, echo_seen_nxt;
  logic               seen_now;

  // result register (held results live here)
  logic               out_valid_r;
  logic               trig_r, trig_nxt;
  logic               done_r, done_nxt;
  logic               tout_r, tout_nxt;
  logic [CM_W-1:0]    cm_r, cm_nxt;
  logic [INCH_W-1:0]  inch_r, inch_nxt;

  logic [SINCE_W-1:0] since_inc;
  logic [CNT_W-1:0]   pcount_inc;
  logic               echo_hit;
  logic               wait_tout;
  logic [CNT_W+CM_MUL_W-1:0]   cm_prod;
  logic [CNT_W+INCH_MUL_W-1:0] inch_prod;

  logic in_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      trig_w_r   <= TRIG_W_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_data;
        CFG_TRIG_W:   trig_w_r   <= cfg_data[CNT_W-1:0];
        CFG_TIMEOUT:  timeout_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // echo edge tracking, runs in every phase
  always_comb begin
    echo_w_nxt = echo_w_r;
    seen_now   = echo_seen_r;
    if (in_echo_level && !echo_prev_r) begin
      echo_w_nxt = CNT_W'(1);
    end else if (in_echo_level && echo_prev_r) begin
      if (echo_w_r != CNT_MAX) echo_w_nxt = echo_w_r + CNT_W'(1);
    end else if (!in_echo_level && echo_prev_r) begin
      seen_now = 1'b1;
    end
  end

  assign since_inc  = (since_r == SINCE_MAX) ? since_r : since_r + SINCE_W'(1);
  assign pcount_inc = (pcount_r == CNT_MAX) ? pcount_r : pcount_r + CNT_W'(1);
  assign echo_hit   = (phase_r == PH_WAIT) && seen_now;
  assign wait_tout  = (phase_r == PH_WAIT) && !seen_now && (pcount_inc >= timeout_r);

  assign cm_prod   = (CNT_W+CM_MUL_W)'(echo_w_nxt) * (CNT_W+CM_MUL_W)'(CM_MUL);
  assign inch_prod = (CNT_W+INCH_MUL_W)'(echo_w_nxt) * (CNT_W+INCH_MUL_W)'(INCH_MUL);

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    since_nxt     = since_r;
    pcount_nxt    = pcount_r;
    echo_seen_nxt = seen_now;
    unique case (phase_r)
      PH_TRIG: begin
        if (pcount_inc >= trig_w_r) begin
          phase_nxt     = PH_WAIT;
          pcount_nxt    = '0;
          echo_seen_nxt = 1'b0; // drop an echo that ended on this tick
        end else begin
          pcount_nxt = pcount_inc;
        end
      end
      PH_WAIT: begin
        if (echo_hit || wait_tout) begin
          phase_nxt  = PH_IDLE;
          since_nxt  = '0;
          pcount_nxt = '0;
        end else begin
          pcount_nxt = pcount_inc;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        since_nxt = since_inc;
        if (since_inc >= interval_r) begin
          phase_nxt  = PH_TRIG;
          pcount_nxt = '0;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    trig_nxt = (phase_nxt == PH_TRIG);
    done_nxt = echo_hit || wait_tout;
    tout_nxt = tout_r;
    cm_nxt   = cm_r;
    inch_nxt = inch_r;
    if (echo_hit) begin
      tout_nxt = 1'b0;
      cm_nxt   = cm_prod[CM_SHIFT +: CM_W];
      inch_nxt = inch_prod[INCH_SHIFT +: INCH_W];
    end else if (wait_tout) begin
      tout_nxt = 1'b1;
      cm_nxt   = '0;
      inch_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      since_r     <= '0;
      pcount_r    <= '0;
      echo_prev_r <= 1'b0;
      echo_w_r    <= '0;
      echo_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
      trig_r      <= 1'b0;
      done_r      <= 1'b0;
      tout_r      <= 1'b0;
      cm_r        <= '0;
      inch_r      <= '0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        since_r     <= since_nxt;
        pcount_r    <= pcount_nxt;
        echo_prev_r <= in_echo_level;
        echo_w_r    <= echo_w_nxt;
        echo_seen_r <= echo_seen_nxt;
        trig_r      <= trig_nxt;
        done_r      <= done_nxt;
        tout_r      <= tout_nxt;
        cm_r        <= cm_nxt;
        inch_r      <= inch_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_trigger_level    = trig_r;
  assign out_measurement_done = done_r;
  assign out_timed_out        = tout_r;
  assign out_distance_cm_q4   = cm_r;
  assign out_distance_inch_q4 = inch_r;

  `URC_ASSERT(a_done_not_trig, done_r |-> !trig_r, "trigger high on a completion tick")
  `URC_ASSERT(a_tout_clears, tout_r |-> (cm_r == '0 && inch_r == '0), "distance held after timeout")
  `URC_ASSERT(a_trig_phase, trig_r == (phase_r == PH_TRIG), "trigger out of step with phase")
  `URC_ASSERT(a_no_overrun, (out_valid_r && !out_ready) |-> !in_ready, "request taken over a pending result")

endmodule
